FILE: design/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared codes and constants for the ROM/RAM bank controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  typedef enum logic [1:0] {
    REGION_FIXED_ROM  = 2'd0,
    REGION_BANKED_ROM = 2'd1,
    REGION_RAM        = 2'd2,
    REGION_NONE       = 2'd3
  } region_t;

  typedef enum logic {
    CFG_ROM_BANK_COUNT = 1'b0,
    CFG_RAM_BYTE_COUNT = 1'b1
  } cfg_index_t;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic       ACCESS_WRITE     = 1'b1;
  localparam logic [3:0] RAM_ENABLE_KEY   = 4'hA;
  localparam logic [6:0] ROM_BANK_RESET   = 7'd1;
  localparam logic [7:0] ROM_COUNT_RESET  = 8'd2;

endpackage

`default_nettype wire

FILE: design/rom_ram_bank_controller_unit.sv
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_unit
// Bank register file and address translation for one CPU bus access per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one bus access: mode, address
//   and write_data. Output channel (out_valid/out_stall) returns one result
//   per access: region, translated ROM/RAM address, RAM write strobe and
//   byte, open bus flag and range fault. Either side transfers at a rising
//   edge with valid high and stall low.
//   The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
//   ROM bank count (index 0) and RAM byte count (index 1); cfg_ready is
//   always high. Write config only while the block is idle.
//   out_valid rises once an access has passed the input register, then
//   decode and bank update into the result register. Throughput is one
//   access per cycle while out_stall is low; the two registers give two
//   entries of buffering. When out_stall holds a waiting result, one more
//   access is taken into the input register, then in_stall rises until the
//   result moves. Reset clears both registers and restores ROM bank 1, RAM
//   bank 0, RAM disabled, ROM banking mode, 2 ROM banks and no RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_ram_bank_controller_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               mode,
  input  wire logic [15:0]                        address,
  input  wire logic [7:0]                         write_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              region,
  output logic [20:0]                             rom_address,
  output logic [14:0]                             ram_address,
  output logic                                    ram_write_strobe,
  output logic [7:0]                              ram_write_byte,
  output logic                                    open_bus,
  output logic                                    fault,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic        s1_valid;
  logic        s1_mode;
  logic [15:0] s1_address;
  logic [7:0]  s1_write_data;
  logic        s1_advance;
  logic        in_accept;

  logic [7:0]  rom_bank_count;
  logic [15:0] ram_byte_count;

  logic        ram_enabled;
  logic [6:0]  rom_bank;
  logic [1:0]  ram_bank;
  logic        banking_mode;
  logic        ram_enabled_next;
  logic [6:0]  rom_bank_next;
  logic [1:0]  ram_bank_next;
  logic        banking_mode_next;

  rbc_pkg::region_t region_next;
  logic [20:0] rom_address_next;
  logic [14:0] ram_address_next;
  logic        ram_write_strobe_next;
  logic [7:0]  ram_write_byte_next;
  logic        open_bus_next;
  logic        fault_next;

  logic [14:0] ram_translated;
  logic        ram_fault;
  logic        rom_banked_fault;
  logic [6:0]  rom_bank_low_wr;
  logic [6:0]  rom_bank_high_wr;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= rbc_pkg::ROM_COUNT_RESET;
      ram_byte_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rbc_pkg::cfg_index_t'(cfg_index))
        rbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data[7:0];
        rbc_pkg::CFG_RAM_BYTE_COUNT: ram_byte_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode       <= mode;
      s1_address    <= address;
      s1_write_data <= write_data;
    end
  end

  // Decode, translation and bank register update.
  assign ram_translated   = {ram_bank, s1_address[12:0]};
  assign ram_fault        = {1'b0, ram_translated} >= ram_byte_count;
  assign rom_banked_fault = {1'b0, rom_bank} >= rom_bank_count;
  assign rom_bank_low_wr  = {rom_bank[6:5], s1_write_data[4:0]};
  assign rom_bank_high_wr = {s1_write_data[1:0], rom_bank[4:0]};

  always_comb begin
    region_next           = rbc_pkg::REGION_NONE;
    rom_address_next      = '0;
    ram_address_next      = '0;
    ram_write_strobe_next = 1'b0;
    ram_write_byte_next   = '0;
    open_bus_next         = 1'b0;
    fault_next            = 1'b0;
    ram_enabled_next      = ram_enabled;
    rom_bank_next         = rom_bank;
    ram_bank_next         = ram_bank;
    banking_mode_next     = banking_mode;

    if (s1_address[15:13] == 3'b101) begin
      region_next      = rbc_pkg::REGION_RAM;
      ram_address_next = ram_translated;
      fault_next       = ram_fault;
      if (s1_mode == rbc_pkg::ACCESS_WRITE && ram_enabled && !ram_fault) begin
        ram_write_strobe_next = 1'b1;
        ram_write_byte_next   = s1_write_data;
      end
    end else if (s1_mode == rbc_pkg::ACCESS_WRITE) begin
      if (!s1_address[15]) begin
        case (s1_address[14:13])
          2'b00: ram_enabled_next = (s1_write_data[3:0] == rbc_pkg::RAM_ENABLE_KEY);
          2'b01: begin
            rom_bank_next = (rom_bank_low_wr == '0) ? rbc_pkg::ROM_BANK_RESET
                                                    : rom_bank_low_wr;
          end
          2'b10: begin
            if (!banking_mode) begin
              rom_bank_next = (rom_bank_high_wr == '0) ? rbc_pkg::ROM_BANK_RESET
                                                       : rom_bank_high_wr;
            end else begin
              ram_bank_next = s1_write_data[1:0];
            end
          end
          2'b11: begin
            banking_mode_next = s1_write_data[0];
            if (!s1_write_data[0]) begin
              ram_bank_next = '0;
            end
          end
          default: ;
        endcase
      end
    end else begin
      if (s1_address[15:14] == 2'b00) begin
        region_next      = rbc_pkg::REGION_FIXED_ROM;
        rom_address_next = {7'd0, s1_address[13:0]};
        fault_next       = (rom_bank_count == '0);
      end else if (s1_address[15:14] == 2'b01) begin
        region_next      = rbc_pkg::REGION_BANKED_ROM;
        rom_address_next = {rom_bank, s1_address[13:0]};
        fault_next       = rom_banked_fault;
      end else begin
        open_bus_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled  <= 1'b0;
      rom_bank     <= rbc_pkg::ROM_BANK_RESET;
      ram_bank     <= '0;
      banking_mode <= 1'b0;
    end else if (s1_advance) begin
      ram_enabled  <= ram_enabled_next;
      rom_bank     <= rom_bank_next;
      ram_bank     <= ram_bank_next;
      banking_mode <= banking_mode_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      region           <= region_next;
      rom_address      <= rom_address_next;
      ram_address      <= ram_address_next;
      ram_write_strobe <= ram_write_strobe_next;
      ram_write_byte   <= ram_write_byte_next;
      open_bus         <= open_bus_next;
      fault            <= fault_next;
    end
  end

`ifndef SYNTHESIS
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    rom_bank != '0)
    else $error("rom bank register holds zero");

  a_ram_bank_rom_mode: assert property (@(posedge clk) disable iff (rst)
    !banking_mode |-> ram_bank == '0)
    else $error("ram bank nonzero in rom banking mode");

  a_strobe_region: assert property (@(posedge clk) disable iff (rst)
    out_valid && ram_write_strobe |-> region == rbc_pkg::REGION_RAM && !fault)
    else $error("ram write strobe outside ram region or with fault");

  a_open_bus_region: assert property (@(posedge clk) disable iff (rst)
    out_valid && open_bus |-> region == rbc_pkg::REGION_NONE && !fault)
    else $error("open bus with mapped region or fault");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while a register is free");
`endif

endmodule

`default_nettype wire
